// ===== rtl/core/bba_pkg.sv =====
// Package: shared types, constants and state codes for the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;
    localparam int POOL_ORDER_DEF = 8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADSIZE = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [8:0] alloc_size;
        logic [7:0] block_address;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_address;
        logic [3:0] granted_order;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_REC_RD,
        S_REC_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_FINISH,
        S_DONE
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_TAKE,
        OP_SPLIT,
        OP_REC_RD,
        OP_REC_TAKE,
        OP_MERGE_RD,
        OP_MERGE,
        OP_FINISH_FREE,
        OP_ERR_NOSPACE,
        OP_ERR_BADSIZE,
        OP_ERR_BADFREE
    } t_op;

    typedef struct packed {
        logic bad_size;
        logic is_free;
        logic bit_set;
        logic scan_last;
        logic split_done;
        logic rec_valid;
        logic merge_top;
    } t_dp_status;
endpackage

// ===== rtl/core/bba_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/core/bba_datapath.sv =====
// Datapath: bitmap and record memories, address and order registers.
`timescale 1ns / 1ps
module bba_datapath
    import bba_pkg::*;
#(
    parameter int POOL_ORDER = POOL_ORDER_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  t_op        i_op,
    output t_dp_status o_stat,
    output t_rsp       o_rsp
);
    localparam int UNITS = 1 << POOL_ORDER;
    localparam int NODES = 2 * UNITS;
    localparam int NW = POOL_ORDER + 1;
    localparam int OW = $clog2(POOL_ORDER + 1);
    localparam int AW = POOL_ORDER;

    // Bitmap: clearing sweep after reset, since the memory has no reset.
    logic          r_clr_busy;
    logic [NW-1:0] r_clr_idx;
    logic [NW-1:0] n_clr_idx;

    logic [OW-1:0] r_n, r_k;
    logic [AW-1:0] r_idx;          // block index within order k
    logic [AW-1:0] r_addr;
    logic [3:0]    r_rec_order;
    logic          r_is_free;
    logic          r_size_bad;
    logic          r_addr_hi;
    t_rsp          r_rsp;

    logic          bm_we;
    logic [NW-1:0] bm_addr;
    logic          bm_wdata, bm_rdata;
    logic          rc_we;
    logic [AW-1:0] rc_addr;
    logic [4:0]    rc_wdata, rc_rdata;

    logic [NW-1:0] count_k, node_scan, node_split, node_buddy, node_fin;
    logic [AW-1:0] buddy_addr;
    logic [AW-1:0] one_k;
    logic [OW-1:0] n_size;
    logic          size_bad;
    logic          addr_hi;

    always_comb begin
        count_k    = NW'(1) << (OW'(POOL_ORDER) - r_k);
        node_scan  = count_k + NW'(r_idx);
        // r_k holds current split order j; upper half of order j-1
        node_split = (NW'(1) << (OW'(POOL_ORDER) - r_k + OW'(1)))
                   + NW'((r_addr + (AW'(1) << (r_k - OW'(1)))) >> (r_k - OW'(1)));
        one_k      = AW'(1) << r_k;
        buddy_addr = r_addr ^ one_k;
        node_buddy = count_k + NW'(buddy_addr >> r_k);
        node_fin   = count_k + NW'(r_addr >> r_k);
    end

    // Round size up to a power of two.
    always_comb begin
        n_size = '0;
        for (int b = POOL_ORDER; b >= 1; b--) begin
            if ((32'(i_req.alloc_size) - 32'd1) >> (b - 1) != 0 && n_size == '0) begin
                n_size = OW'(b);
            end
        end
        size_bad = (i_req.alloc_size == '0) || (32'(i_req.alloc_size) > UNITS);
        addr_hi  = (32'(i_req.block_address) >= UNITS);
    end

    always_comb begin
        bm_we    = 1'b0;
        bm_addr  = node_scan;
        bm_wdata = 1'b0;
        rc_we    = 1'b0;
        rc_addr  = r_addr;
        rc_wdata = '0;
        n_clr_idx = r_clr_idx + NW'(1);
        if (r_clr_busy) begin
            bm_we    = 1'b1;
            bm_addr  = r_clr_idx;
            bm_wdata = (r_clr_idx == NW'(1));
        end else begin
            unique case (i_op)
                OP_TAKE: begin
                    bm_we = 1'b1; bm_addr = node_scan; bm_wdata = 1'b0;
                end
                OP_SPLIT: begin
                    bm_we = 1'b1; bm_addr = node_split; bm_wdata = 1'b1;
                end
                OP_MERGE_RD: bm_addr = node_buddy;
                OP_MERGE: begin
                    bm_we = 1'b1; bm_addr = node_buddy; bm_wdata = 1'b0;
                end
                OP_FINISH_FREE: begin
                    bm_we = 1'b1; bm_addr = node_fin; bm_wdata = 1'b1;
                end
                OP_REC_RD: rc_addr = r_addr;
                // drop the record at the block start before merging moves r_addr
                OP_REC_TAKE: begin
                    rc_we = 1'b1; rc_wdata = '0;
                end
                default: ;
            endcase
            if (i_op == OP_SPLIT && r_k == r_n) begin
                bm_we = 1'b0;
            end
            if (i_op == OP_SPLIT && r_k == r_n) begin
                rc_we    = 1'b1;
                rc_wdata = {1'b1, 4'(r_n)};
            end
        end
    end

    bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_addr(bm_addr),
        .i_wdata(bm_wdata), .o_rdata(bm_rdata)
    );

    // Record memory: cleared alongside the bitmap sweep.
    bba_ram #(.WIDTH(5), .DEPTH(UNITS)) u_record (
        .i_clk(i_clk), .i_we(rc_we || r_clr_busy),
        .i_addr(r_clr_busy ? r_clr_idx[AW-1:0] : rc_addr),
        .i_wdata(r_clr_busy ? 5'd0 : rc_wdata), .o_rdata(rc_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= n_clr_idx;
            if (r_clr_idx == NW'(NODES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_n   <= n_size;
                r_k   <= n_size;
                r_idx <= '0;
                r_addr <= AW'(i_req.block_address);
                r_is_free  <= i_req.req_type;
                r_size_bad <= size_bad;
                r_addr_hi  <= addr_hi;
                r_rsp <= '0;
            end
            OP_SCAN_NEXT: begin
                if (r_idx == AW'((count_k - NW'(1)))) begin
                    r_idx <= '0;
                    r_k   <= r_k + OW'(1);
                end else begin
                    r_idx <= r_idx + AW'(1);
                end
            end
            OP_TAKE: r_addr <= AW'(32'(r_idx) << r_k);
            OP_SPLIT: begin
                if (r_k == r_n) begin
                    r_rsp.status          <= ST_OK;
                    r_rsp.granted_address <= 8'(r_addr);
                    r_rsp.granted_order   <= 4'(r_n);
                end else begin
                    r_k <= r_k - OW'(1);
                end
            end
            OP_REC_TAKE: begin
                r_rec_order <= (32'(rc_rdata[3:0]) > POOL_ORDER)
                             ? 4'(POOL_ORDER) : rc_rdata[3:0];
                r_k <= (32'(rc_rdata[3:0]) > POOL_ORDER)
                     ? OW'(POOL_ORDER) : OW'(rc_rdata[3:0]);
            end
            OP_MERGE: begin
                r_addr <= r_addr & ~one_k;
                r_k    <= r_k + OW'(1);
            end
            OP_FINISH_FREE: begin
                r_rsp.status        <= ST_OK;
                r_rsp.granted_order <= r_rec_order;
            end
            OP_ERR_NOSPACE: r_rsp.status <= ST_NOSPACE;
            OP_ERR_BADSIZE: r_rsp.status <= ST_BADSIZE;
            OP_ERR_BADFREE: r_rsp.status <= ST_BADFREE;
            default: ;
        endcase
    end

    always_comb begin
        o_stat.bad_size   = r_size_bad || r_clr_busy;
        o_stat.is_free    = r_is_free;
        o_stat.bit_set    = bm_rdata;
        o_stat.scan_last  = (r_idx == AW'((count_k - NW'(1))))
                          && (r_k == OW'(POOL_ORDER));
        o_stat.split_done = (r_k == r_n);
        o_stat.rec_valid  = rc_rdata[4] && !r_addr_hi;
        o_stat.merge_top  = (r_k == OW'(POOL_ORDER));
        o_rsp             = r_rsp;
    end
endmodule

// ===== rtl/core/bba_ctrl.sv =====
// Controller: sequences allocate scans and splits, and free merges.
`timescale 1ns / 1ps
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_clr_busy,
    input  t_dp_status i_stat,
    output t_op        o_op,
    output logic       o_busy,
    output logic       o_done
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_start && !i_clr_busy) n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.is_free) n_state = S_REC_RD;
                else if (i_stat.bad_size) n_state = S_DONE;
                else n_state = S_SCAN_RD;
            end
            S_SCAN_RD:   n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_stat.bit_set) n_state = S_SPLIT;
                else if (i_stat.scan_last) n_state = S_DONE;
                else n_state = S_SCAN_RD;
            end
            S_SPLIT:     if (i_stat.split_done) n_state = S_DONE;
            S_REC_RD:    n_state = S_REC_CHK;
            S_REC_CHK:   n_state = i_stat.rec_valid ? S_MERGE_RD : S_DONE;
            S_MERGE_RD:  n_state = i_stat.merge_top ? S_FINISH : S_MERGE_CHK;
            S_MERGE_CHK: n_state = i_stat.bit_set ? S_MERGE_RD : S_FINISH;
            S_FINISH:    n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = OP_NONE;
        o_busy = (r_state != S_IDLE) || i_clr_busy;
        o_done = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE:     if (i_start && !i_clr_busy) o_op = OP_LOAD;
            S_CHECK:    if (!i_stat.is_free && i_stat.bad_size) o_op = OP_ERR_BADSIZE;
            S_SCAN_RD:  o_op = OP_SCAN_RD;
            S_SCAN_CHK: begin
                if (i_stat.bit_set) o_op = OP_TAKE;
                else if (i_stat.scan_last) o_op = OP_ERR_NOSPACE;
                else o_op = OP_SCAN_NEXT;
            end
            S_SPLIT:    o_op = OP_SPLIT;
            S_REC_RD:   o_op = OP_REC_RD;
            S_REC_CHK:  o_op = i_stat.rec_valid ? OP_REC_TAKE : OP_ERR_BADFREE;
            S_MERGE_RD: o_op = i_stat.merge_top ? OP_NONE : OP_MERGE_RD;
            S_MERGE_CHK: if (i_stat.bit_set) o_op = OP_MERGE;
            S_FINISH:   o_op = OP_FINISH_FREE;
            default:    o_op = OP_NONE;
        endcase
    end
endmodule

// ===== rtl/core/buddy_block_allocator_unit.sv =====
// Buddy block allocator: one request per transaction, one result strobe.
// Allocate scans the free blocks, then splits one level at a time; free reads the record, then
// merges buddies up to the whole pool; bad size, bad free and no space end with an error status.
// One transaction at a time, the next accepted the cycle after the strobe; the bitmap memory is
// single-port, one access a cycle.
// Reset: synchronous active-low; a clearing pass follows, busy high.
`timescale 1ns / 1ps
module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int POOL_ORDER = POOL_ORDER_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);
    t_op        op;
    t_dp_status stat;

    // Mirror of the clearing pass length so the controller holds off requests.
    logic [POOL_ORDER+1:0] r_sweep_cnt;
    logic                  r_sweep;

    bba_datapath #(.POOL_ORDER(POOL_ORDER)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req),
        .i_op(op), .o_stat(stat), .o_rsp(o_rsp)
    );

    bba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_clr_busy(r_sweep), .i_stat(stat),
        .o_op(op), .o_busy(busy), .o_done(o_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_sweep     <= 1'b1;
        end else if (r_sweep) begin
            r_sweep_cnt <= r_sweep_cnt + (POOL_ORDER+2)'(1);
            if (r_sweep_cnt == (POOL_ORDER+2)'((1 << (POOL_ORDER + 1)) - 1)) begin
                r_sweep <= 1'b0;
            end
        end
    end

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside a transaction");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> busy) else $error("request possible during clearing pass");
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.granted_order == '0))
        else $error("order reported on an error result");
endmodule

// ===== tb/bba_checker.sv =====
// Checker: predicts allocator results from observed requests and compares them.
`timescale 1ns / 1ps
module bba_checker
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_req,
    input  logic        i_valid,
    input  t_rsp        i_rsp,
    output int          o_errors,
    output int          o_pending
);
    localparam int P     = POOL_ORDER_DEF;
    localparam int UNITS = 1 << P;

    logic       free_map [2*UNITS];
    logic [4:0] owner_rec [UNITS];
    t_rsp       rsp_q [$];

    function automatic void clear_pool();
        foreach (free_map[i]) free_map[i] = 1'b0;
        foreach (owner_rec[i]) owner_rec[i] = '0;
        free_map[1] = 1'b1;
    endfunction

    function automatic int node_idx(int order, int addr);
        return (1 << (P - order)) + (addr >> order);
    endfunction

    function automatic t_rsp allocate_or_release(t_req r);
        t_rsp res;
        int   size, n, k, i, j, cnt, addr, ro, buddy;
        bit   found;
        res   = '0;
        found = 0;
        if (!r.req_type) begin
            size = r.alloc_size;
            if (size == 0 || size > UNITS) begin
                res.status = ST_BADSIZE;
                return res;
            end
            n = 0;
            while ((1 << n) < size) n++;
            for (k = n; k <= P && !found; k++) begin
                cnt = 1 << (P - k);
                for (i = 0; i < cnt && !found; i++) begin
                    if (free_map[cnt + i]) begin
                        found = 1;
                        addr  = i << k;
                        free_map[cnt + i] = 1'b0;
                        // mark the upper half free at each level split off
                        for (j = k; j > n; j--)
                            free_map[node_idx(j - 1, addr + (1 << (j - 1)))] = 1'b1;
                        owner_rec[addr]     = {1'b1, 4'(n)};
                        res.status          = ST_OK;
                        res.granted_address = 8'(addr);
                        res.granted_order   = 4'(n);
                    end
                end
            end
            if (!found) res.status = ST_NOSPACE;
            return res;
        end
        addr = r.block_address;
        if (!owner_rec[addr][4]) begin
            res.status = ST_BADFREE;
            return res;
        end
        ro = owner_rec[addr][3:0];
        if (ro > P) ro = P;
        owner_rec[addr] = '0;
        n    = ro;
        addr = addr & ~((1 << n) - 1);
        while (n < P) begin
            buddy = addr ^ (1 << n);
            if (!free_map[node_idx(n, buddy)]) break;
            free_map[node_idx(n, buddy)] = 1'b0;
            addr = addr & ~(1 << n);
            n++;
        end
        free_map[node_idx(n, addr)] = 1'b1;
        res.status        = ST_OK;
        res.granted_order = 4'(ro);
        return res;
    endfunction

    initial begin
        o_errors = 0;
        clear_pool();
    end

    assign o_pending = rsp_q.size();

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            clear_pool();
            rsp_q.delete();
        end else begin
            // compare first: a result never shares an edge with its own request
            if (i_valid) begin
                if (rsp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rsp_q.pop_front();
                    if (i_rsp.status !== want.status ||
                        i_rsp.granted_address !== want.granted_address ||
                        i_rsp.granted_order !== want.granted_order) begin
                        $display({"%0t: result error, expected st=%0d addr=%0d ord=%0d,",
                                  " actual st=%0d addr=%0d ord=%0d"},
                                 $time, want.status, want.granted_address,
                                 want.granted_order, i_rsp.status,
                                 i_rsp.granted_address, i_rsp.granted_order);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) rsp_q = {rsp_q, allocate_or_release(i_req)};
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives allocate and free transactions and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
    import bba_pkg::*;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;
    localparam int   N_RANDOM  = 1400;
    localparam int   CALM_TAIL = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_valid;
    t_rsp o_rsp;
    int   errors, pending;
    logic kind_q [$];
    int   owned [$];
    bit   calm = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    buddy_block_allocator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    bba_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_req(i_req),
        .i_valid(o_valid), .i_rsp(o_rsp), .o_errors(errors), .o_pending(pending)
    );

    // track granted blocks so most frees name a live allocation
    always @(posedge i_clk) begin
        logic k;
        if (i_rst_n && o_valid && kind_q.size() > 0) begin
            k = kind_q.pop_front();
            if (k == REQ_ALLOC && o_rsp.status == ST_OK)
                owned = {owned, int'(o_rsp.granted_address)};
        end
    end

    task automatic issue(logic kind, int size, int addr);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{req_type: kind, alloc_size: 9'(size), block_address: 8'(addr)};
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        kind_q = {kind_q, kind};
    endtask

    task automatic release_owned();
        int idx, a;
        idx = $urandom_range(0, owned.size() - 1);
        a = owned[idx];
        owned.delete(idx);
        issue(REQ_FREE, $urandom_range(0, 511), a);
    endtask

    initial begin
        int i, r, sz;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // whole pool, exhaustion, double free, bad sizes
        issue(REQ_ALLOC, 256, 0);
        issue(REQ_ALLOC, 1, 0);
        issue(REQ_FREE, 0, 0);
        issue(REQ_FREE, 0, 0);
        issue(REQ_ALLOC, 0, 0);
        issue(REQ_ALLOC, 257, 0);
        issue(REQ_ALLOC, 511, 255);
        issue(REQ_ALLOC, 1, 0);
        issue(REQ_ALLOC, 2, 0);
        issue(REQ_ALLOC, 3, 0);
        issue(REQ_ALLOC, 5, 0);
        issue(REQ_ALLOC, 128, 0);
        issue(REQ_ALLOC, 128, 0);
        issue(REQ_FREE, 0, 255);
        issue(REQ_FREE, 0, 1);
        issue(REQ_FREE, 0, 128);
        issue(REQ_FREE, 0, 0);
        issue(REQ_FREE, 0, 2);
        issue(REQ_FREE, 0, 4);
        issue(REQ_FREE, 0, 8);
        issue(REQ_ALLOC, 256, 170);
        issue(REQ_FREE, 511, 0);
        for (i = 0; i < N_RANDOM; i++) begin
            calm = (i >= N_RANDOM - CALM_TAIL);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                sz = $urandom_range(0, 9);
                if (sz < 6) sz = $urandom_range(1, 8);
                else if (sz < 8) sz = $urandom_range(1, 64);
                else if (sz < 9) sz = $urandom_range(65, 256);
                else sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(257, 511);
                issue(REQ_ALLOC, sz, $urandom_range(0, 255));
            end else if (r < 93 && owned.size() > 0) begin
                release_owned();
            end else begin
                issue(REQ_FREE, $urandom_range(0, 511), $urandom_range(0, 255));
            end
        end
        start <= 1'b0;
        while (pending != 0 || kind_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("buddy_block_allocator_unit: match");
        else
            $display("buddy_block_allocator_unit: mismatch");
        $finish;
    end

    initial begin
        #200ms;
        $display("buddy_block_allocator_unit: mismatch");
        $finish;
    end
endmodule
